>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants of the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int COUNT_LIMIT_DEF = 255;
  localparam int TIME_BITS_DEF   = 32;

  localparam int CFG_W = 16;

  localparam logic [0:0] REG_DEBOUNCE  = 1'b0;
  localparam logic [0:0] REG_LONG_HOLD = 1'b1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CFG_W-1:0] LONG_HOLD_RST = 16'd5000;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic last_raw;
    logic stable_level;
    logic press_active;
    logic long_reported;
    logic long_pending;
  } flags_t;

endpackage

>>> sv/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a polled button and counts short presses and long holds.
// ----------------------------------------------------------------------------
// Each input beat is one poll sample of the button with a millisecond
// timestamp and two take requests. Each input beat yields exactly one output
// beat with the take results, the pending short count and the debounced level.
// The sample is registered on acceptance in the input register, processed by
// the update logic once the output register is free, and the result is held
// in the output register. One beat is taken per cycle while the output side
// keeps up; the limit is the state update of each beat.
// When the receiver stalls, the output register holds its beat and the input
// register holds one more, after which in_tready drops.
// Reset clears the valid flags of both registers, all press state and the
// short count, and sets the debounce time to 50 ms and the long hold time to
// 5000 ms. Configuration writes take effect at the next clock edge.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier #(
  parameter int TIME_BITS   = bdpc_pkg::TIME_BITS_DEF,
  parameter int COUNT_LIMIT = bdpc_pkg::COUNT_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // raw_pressed[0], now_time[32:1], take_short[33], take_long[34], zero pad
  input  logic [bdpc_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // short_taken[0], long_taken[1], pending_short[9:2], debounced_level[10],
  // zero pad
  output logic [bdpc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [0:0]                          cfg_addr,
  input  logic [bdpc_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int CNT_W = $clog2(COUNT_LIMIT + 1);

  logic                          in_valid_r;
  logic                          raw_r;
  logic [31:0]                   now_r;
  logic                          tshort_r;
  logic                          tlong_r;
  logic                          out_valid_r;
  logic [bdpc_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [bdpc_pkg::CFG_W-1:0]    debounce_r;
  logic [bdpc_pkg::CFG_W-1:0]    long_hold_r;
  bdpc_pkg::flags_t              flags_r;
  bdpc_pkg::flags_t              flags_nxt;
  logic [TIME_BITS-1:0]          rct_r;
  logic [TIME_BITS-1:0]          rct_nxt;
  logic [TIME_BITS-1:0]          pst_r;
  logic [TIME_BITS-1:0]          pst_nxt;
  logic [CNT_W-1:0]              cnt_r;
  logic [CNT_W-1:0]              cnt_nxt;
  logic                          s_taken;
  logic                          l_taken;
  logic                          advance;
  logic                          fire;
  logic                          in_acc;

  assign advance    = !out_valid_r || out_tready;
  assign fire       = in_valid_r && advance;
  assign in_tready  = !in_valid_r || advance;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  bdpc_core #(
    .TIME_BITS   (TIME_BITS),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_core (
    .flags                (flags_r),
    .raw_change_time      (rct_r),
    .press_start_time     (pst_r),
    .short_count          (cnt_r),
    .debounce_time        (debounce_r),
    .long_hold_time       (long_hold_r),
    .raw_pressed          (raw_r),
    .now_time             (now_r),
    .take_short           (tshort_r),
    .take_long            (tlong_r),
    .flags_nxt            (flags_nxt),
    .raw_change_time_nxt  (rct_nxt),
    .press_start_time_nxt (pst_nxt),
    .short_count_nxt      (cnt_nxt),
    .short_taken          (s_taken),
    .long_taken           (l_taken)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= bdpc_pkg::DEBOUNCE_RST;
      long_hold_r <= bdpc_pkg::LONG_HOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        bdpc_pkg::REG_DEBOUNCE:  debounce_r  <= cfg_wdata;
        bdpc_pkg::REG_LONG_HOLD: long_hold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_r    <= in_tdata[0];
      now_r    <= in_tdata[32:1];
      tshort_r <= in_tdata[33];
      tlong_r  <= in_tdata[34];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      rct_r   <= '0;
      pst_r   <= '0;
      cnt_r   <= '0;
    end else if (fire) begin
      flags_r <= flags_nxt;
      rct_r   <= rct_nxt;
      pst_r   <= pst_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {5'b0, flags_nxt.stable_level, 8'(cnt_nxt), l_taken, s_taken};
    end
  end

endmodule

>>> sv/bdpc_core.sv
// ----------------------------------------------------------------------------
// bdpc_core
// Per-sample update: debounce, press classification and take requests.
// ----------------------------------------------------------------------------
module bdpc_core #(
  parameter int TIME_BITS   = bdpc_pkg::TIME_BITS_DEF,
  parameter int COUNT_LIMIT = bdpc_pkg::COUNT_LIMIT_DEF,
  localparam int CNT_W      = $clog2(COUNT_LIMIT + 1)
) (
  input  bdpc_pkg::flags_t              flags,
  input  logic [TIME_BITS-1:0]          raw_change_time,
  input  logic [TIME_BITS-1:0]          press_start_time,
  input  logic [CNT_W-1:0]              short_count,
  input  logic [bdpc_pkg::CFG_W-1:0]    debounce_time,
  input  logic [bdpc_pkg::CFG_W-1:0]    long_hold_time,
  input  logic                          raw_pressed,
  input  logic [31:0]                   now_time,
  input  logic                          take_short,
  input  logic                          take_long,
  output bdpc_pkg::flags_t              flags_nxt,
  output logic [TIME_BITS-1:0]          raw_change_time_nxt,
  output logic [TIME_BITS-1:0]          press_start_time_nxt,
  output logic [CNT_W-1:0]              short_count_nxt,
  output logic                          short_taken,
  output logic                          long_taken
);

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] deb_t;
  logic [TIME_BITS-1:0] hold_t;
  logic [TIME_BITS-1:0] raw_elapsed;
  logic [TIME_BITS-1:0] press_elapsed;
  logic [TIME_BITS-1:0] hold_elapsed;
  logic                 settle;
  logic                 count_up;
  logic [CNT_W-1:0]     cnt_mid;
  bdpc_pkg::flags_t     f;

  assign now_t  = TIME_BITS'(now_time);
  assign deb_t  = TIME_BITS'(debounce_time);
  assign hold_t = TIME_BITS'(long_hold_time);

  always_comb begin
    f                   = flags;
    raw_change_time_nxt = raw_change_time;
    press_start_time_nxt = press_start_time;
    count_up            = 1'b0;
    short_taken         = 1'b0;
    long_taken          = 1'b0;

    if (raw_pressed != flags.last_raw) begin
      f.last_raw          = raw_pressed;
      raw_change_time_nxt = now_t;
    end

    raw_elapsed   = now_t - raw_change_time_nxt;
    press_elapsed = now_t - press_start_time;
    settle        = (raw_pressed != flags.stable_level) && (raw_elapsed >= deb_t);

    if (settle) begin
      f.stable_level = raw_pressed;
      if (raw_pressed) begin
        press_start_time_nxt = now_t;
        f.press_active       = 1'b1;
        f.long_reported      = 1'b0;
      end else if (flags.press_active) begin
        f.press_active  = 1'b0;
        count_up        = !flags.long_reported && (press_elapsed >= deb_t) &&
                          (short_count < CNT_W'(COUNT_LIMIT));
        f.long_reported = 1'b0;
      end
    end

    hold_elapsed = now_t - press_start_time_nxt;
    if (f.stable_level && f.press_active && !f.long_reported && hold_elapsed >= hold_t) begin
      f.long_reported = 1'b1;
      f.long_pending  = 1'b1;
    end

    if (!f.stable_level && !f.press_active) begin
      f.long_reported = 1'b0;
    end

    cnt_mid         = count_up ? short_count + CNT_W'(1) : short_count;
    short_count_nxt = cnt_mid;
    if (take_short && (cnt_mid != '0)) begin
      short_count_nxt = cnt_mid - CNT_W'(1);
      short_taken     = 1'b1;
    end
    if (take_long && f.long_pending) begin
      f.long_pending = 1'b0;
      long_taken     = 1'b1;
    end

    flags_nxt = f;
  end

endmodule

>>> sv/bdpc_checker.sv
// ----------------------------------------------------------------------------
// bdpc_checker
// Port-level checks of the button debounce and press classifier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdpc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bdpc_pkg::OUT_DATA_W-1:0] out_tdata
);

  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "stalled output beat changed")
  `ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_tvalid, "output valid right after reset")
  `ASSERT_CLKD(a_pad_zero, clk, rst_n, out_tvalid |-> out_tdata[15:11] == 5'b0, "output padding bits not zero")
  `ASSERT_CLKD(a_ready_empty, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty output")

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
